// ===== src/gpak_pkg.sv =====
// Shared types, constants and feedback arithmetic of the GPA keystream generator.
`timescale 1ns / 1ps
`default_nettype none
package gpak_pkg;

    localparam int unsigned R_DEPTH = 7;
    localparam int unsigned S_DEPTH = 7;
    localparam int unsigned T_DEPTH = 5;

    localparam logic [4:0] MOD_31  = 5'h1f;
    localparam logic [6:0] MOD_127 = 7'h7f;

    localparam logic CMD_CLOCK = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef logic [4:0] r_cell_t;
    typedef logic [6:0] s_cell_t;
    typedef logic [4:0] t_cell_t;
    typedef logic [7:0] count_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // One's-complement style add: subtract the modulus once when the sum exceeds it.
    function automatic logic [4:0] add_mod31(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] sum;
        logic [5:0] red;
        sum = {1'b0, a} + {1'b0, b};
        red = sum - {1'b0, MOD_31};
        return (sum > {1'b0, MOD_31}) ? red[4:0] : sum[4:0];
    endfunction

    function automatic logic [6:0] add_mod127(input logic [6:0] a, input logic [6:0] b);
        logic [7:0] sum;
        logic [7:0] red;
        sum = {1'b0, a} + {1'b0, b};
        red = sum - {1'b0, MOD_127};
        return (sum > {1'b0, MOD_127}) ? red[6:0] : sum[6:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/gpa_keystream_generator_unit.sv =====
// Top level of the GPA keystream generator: register file, step sequencer, result register.
//
// Usage:
//   Input channel (item_valid / item_stall) carries command, data_byte and
//   repeat_count. A clock command runs repeat_count generator clocks with the
//   same data byte; a clear command zeroes all cells and the output byte.
//   Output channel (result_valid / result_stall) returns one keystream_byte
//   per item: the output byte after the clocks, or zero after a clear.
//   The generator step logic runs one clock per cycle while generator clocks
//   of the item remain; a clear runs none. The finished output byte is then
//   registered as the result once the output register is free.
//   The block takes a new item while the previous result still waits in the
//   output register; a finished item then holds in the sequencer until that
//   register frees up. item_stall is high while an item is in progress.
//   Reset (rst_n low, asynchronous) clears all cells, the output byte, the
//   sequencer and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none
module gpa_keystream_generator_unit
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic       command,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] repeat_count,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [7:0]      keystream_byte
);

    gpak_pkg::state_t  state_reg, state_next;
    gpak_pkg::count_t  count_reg, count_next;
    logic [7:0]        din_reg, din_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    gpak_pkg::r_cell_t r_reg [gpak_pkg::R_DEPTH];
    gpak_pkg::r_cell_t r_next [gpak_pkg::R_DEPTH];
    gpak_pkg::s_cell_t s_reg [gpak_pkg::S_DEPTH];
    gpak_pkg::s_cell_t s_next [gpak_pkg::S_DEPTH];
    gpak_pkg::t_cell_t t_reg [gpak_pkg::T_DEPTH];
    gpak_pkg::t_cell_t t_next [gpak_pkg::T_DEPTH];
    logic              result_valid_reg, result_valid_next;
    logic [7:0]        result_reg, result_next;

    // Generator step, computed from the current cells
    logic [7:0]        mix;
    gpak_pkg::r_cell_t ri;
    gpak_pkg::s_cell_t si;
    gpak_pkg::t_cell_t ti;
    gpak_pkg::r_cell_t r_fb;
    gpak_pkg::s_cell_t s_fb;
    gpak_pkg::t_cell_t t_fb;
    logic [3:0]        nib;

    logic item_xfer;
    logic slot_free;

    assign item_stall     = (state_reg != gpak_pkg::ST_IDLE);
    assign item_xfer      = item_valid && !item_stall;
    assign slot_free      = !result_valid_reg || !result_stall;
    assign result_valid   = result_valid_reg;
    assign keystream_byte = result_reg;

    always_comb
    begin
        mix  = din_reg ^ out_byte_reg;
        ri   = mix[4:0];
        si   = {mix[3:0], mix[7:5]};
        ti   = mix[7:3];
        r_fb = gpak_pkg::add_mod31(r_reg[3], {r_reg[6][3:0], r_reg[6][4]});
        s_fb = gpak_pkg::add_mod127(s_reg[5], {s_reg[6][5:0], s_reg[6][6]});
        t_fb = gpak_pkg::add_mod31(t_reg[4], t_reg[2]);
        // new R4 is old R3, new T3 is old T2
        nib  = (~s_fb[3:0] & (r_fb[3:0] ^ r_reg[3][3:0]))
             | ( s_fb[3:0] & (t_fb[3:0] ^ t_reg[2][3:0]));
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        din_next          = din_reg;
        out_byte_next     = out_byte_reg;
        r_next            = r_reg;
        s_next            = s_reg;
        t_next            = t_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            gpak_pkg::ST_IDLE:
            begin
                if (item_xfer)
                begin
                    din_next   = data_byte;
                    state_next = gpak_pkg::ST_RUN;
                    if (command == gpak_pkg::CMD_CLEAR)
                    begin
                        count_next    = '0;
                        out_byte_next = '0;
                        r_next        = '{default: '0};
                        s_next        = '{default: '0};
                        t_next        = '{default: '0};
                    end
                    else
                    begin
                        count_next = repeat_count;
                    end
                end
            end
            gpak_pkg::ST_RUN:
            begin
                if (count_reg != '0)
                begin
                    // advance all three registers by one generator clock
                    r_next[6] = r_reg[5];
                    r_next[5] = r_reg[4];
                    r_next[4] = r_reg[3];
                    r_next[3] = r_reg[2] ^ ri;
                    r_next[2] = r_reg[1];
                    r_next[1] = r_reg[0];
                    r_next[0] = r_fb;
                    s_next[6] = s_reg[5];
                    s_next[5] = s_reg[4] ^ si;
                    s_next[4] = s_reg[3];
                    s_next[3] = s_reg[2];
                    s_next[2] = s_reg[1];
                    s_next[1] = s_reg[0];
                    s_next[0] = s_fb;
                    t_next[4] = t_reg[3];
                    t_next[3] = t_reg[2];
                    t_next[2] = t_reg[1] ^ ti;
                    t_next[1] = t_reg[0];
                    t_next[0] = t_fb;
                    out_byte_next = {out_byte_reg[3:0], nib};
                    count_next    = count_reg - 8'd1;
                end
                else if (slot_free)
                begin
                    result_next       = out_byte_reg;
                    result_valid_next = 1'b1;
                    state_next        = gpak_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gpak_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gpak_pkg::ST_IDLE;
            count_reg        <= '0;
            out_byte_reg     <= '0;
            r_reg            <= '{default: '0};
            s_reg            <= '{default: '0};
            t_reg            <= '{default: '0};
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            out_byte_reg     <= out_byte_next;
            r_reg            <= r_next;
            s_reg            <= s_next;
            t_reg            <= t_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        din_reg    <= din_next;
        result_reg <= result_next;
    end

endmodule
`default_nettype wire

// ===== src/gpak_checker.sv =====
// Port-level checks of the GPA keystream generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gpak_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_stall,
    input wire logic       command,
    input wire logic [7:0] repeat_count,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [7:0] keystream_byte
);

    logic item_xfer;
    assign item_xfer = item_valid && !item_stall;

    // a stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(keystream_byte))
        else $error("result changed while stalled");

    // an accepted item keeps the input side busy in the cycle after the transfer
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> item_stall)
        else $error("input not stalled after transfer");

    // a clear with a free output slot passes through the run state and returns zero in the result register
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && (command == gpak_pkg::CMD_CLEAR) && !result_valid
        |-> ##2 (result_valid && (keystream_byte == 8'h00)))
        else $error("clear did not return zero");

    // a zero-count clock with a free slot passes through the run state and finishes with its result registered
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && (command == gpak_pkg::CMD_CLOCK) && (repeat_count == 8'd0)
        && !result_valid |-> ##2 (result_valid && !item_stall))
        else $error("zero-count item did not finish in time");

endmodule

bind gpa_keystream_generator_unit gpak_checker u_gpak_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .command        (command),
    .repeat_count   (repeat_count),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .keystream_byte (keystream_byte)
);
`default_nettype wire
